// File: src/wwrs_pkg.sv
// Package for the weekly window relay scheduler.
// Holds field widths, register codes, override modes and the window type.
// No dependencies.
`default_nettype none

package wwrs_pkg;

  localparam int unsigned DayW     = 3;
  localparam int unsigned MinuteW  = 11;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned DaysW    = 7;
  localparam int unsigned CfgDataW = 29;

  localparam logic [MinuteW-1:0] MinutesPerDay = 11'd1440;
  localparam logic [DayW-1:0]    LastDay       = 3'd6;
  localparam logic [DayW-1:0]    FirstDay      = 3'd0;

  // Register index of the override mode; windows follow at 1, 2, ...
  localparam int unsigned CfgIdxMode = 0;

  typedef enum logic [ModeW-1:0] {
    MODE_SCHEDULE  = 2'd0,
    MODE_FORCE_ON  = 2'd1,
    MODE_FORCE_OFF = 2'd2
  } mode_e;

  typedef struct packed {
    logic [MinuteW-1:0] off_minute;
    logic [MinuteW-1:0] on_minute;
    logic [DaysW-1:0]   day_mask;
  } window_t;

endpackage

`default_nettype wire

// File: src/wwrs_tick_if.sv
// Tick channel: one word per clock tick, day, minute and clock-valid flag.
// Depends on wwrs_pkg.
`default_nettype none

interface wwrs_tick_if import wwrs_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [DayW-1:0]    day_of_week;
  logic [MinuteW-1:0] minute_of_day;
  logic               clock_valid;

  modport source (
    output valid, day_of_week, minute_of_day, clock_valid,
    input  ready
  );

  modport sink (
    input  valid, day_of_week, minute_of_day, clock_valid,
    output ready
  );

endinterface

`default_nettype wire

// File: src/wwrs_relay_if.sv
// Relay channel: one word per tick, relay drive and changed flag.
// Depends on wwrs_pkg.
`default_nettype none

interface wwrs_relay_if import wwrs_pkg::*; ();

  logic valid;
  logic ready;
  logic relay_on;
  logic relay_changed;

  modport source (
    output valid, relay_on, relay_changed,
    input  ready
  );

  modport sink (
    input  valid, relay_on, relay_changed,
    output ready
  );

endinterface

`default_nettype wire

// File: src/weekly_window_relay_scheduler.sv
// Weekly window relay scheduler, top level.
// An accepted tick goes into the input register; the result register then holds its relay word.
// Throughput: one tick per cycle while the relay channel is ready; an empty input
// register can still take a tick while the result register waits on the relay channel.
// Reset: relay off, override mode schedule, all windows cleared.
// Depends on wwrs_pkg, wwrs_tick_if, wwrs_relay_if, wwrs_cfg_regs, wwrs_window_match.
`default_nettype none

module weekly_window_relay_scheduler import wwrs_pkg::*; #(
  parameter int unsigned NUM_WINDOWS = 4,
  parameter int unsigned CfgIdxW     = $clog2(NUM_WINDOWS + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  wwrs_tick_if.sink                tick,
  wwrs_relay_if.source             relay,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  logic [ModeW-1:0]   mode;
  window_t            win [NUM_WINDOWS];
  logic [NUM_WINDOWS-1:0] active;

  logic               in_valid_q;
  logic [DayW-1:0]    day_q;
  logic [MinuteW-1:0] minute_q;
  logic               clk_ok_q;

  logic               out_valid_q;
  logic               relay_q;
  logic               changed_q;

  logic               advance;
  logic               tick_take;
  logic               clock_good;
  logic               relay_d;

  wwrs_cfg_regs #(
    .NUM_WINDOWS (NUM_WINDOWS),
    .CfgIdxW     (CfgIdxW)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mode_o      (mode),
    .win_o       (win)
  );

  for (genvar k = 0; k < NUM_WINDOWS; k++) begin : g_match
    wwrs_window_match u_match (
      .win_i    (win[k]),
      .day_i    (day_q),
      .minute_i (minute_q),
      .active_o (active[k])
    );
  end

  assign advance    = !out_valid_q || relay.ready;
  assign tick.ready = !in_valid_q || advance;
  assign tick_take  = tick.valid && tick.ready;

  // hold the tick word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (tick_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_take) begin
      day_q    <= tick.day_of_week;
      minute_q <= tick.minute_of_day;
      clk_ok_q <= tick.clock_valid;
    end
  end

  assign clock_good = clk_ok_q && (day_q <= LastDay) && (minute_q < MinutesPerDay);

  always_comb begin
    case (mode)
      MODE_FORCE_ON:  relay_d = 1'b1;
      MODE_FORCE_OFF: relay_d = 1'b0;
      default:        relay_d = clock_good ? (|active) : relay_q;
    endcase
  end

  // advance the relay state and the result word together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      relay_q     <= 1'b0;
      changed_q   <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        relay_q   <= relay_d;
        changed_q <= relay_d ^ relay_q;
      end
    end
  end

  assign relay.valid         = out_valid_q;
  assign relay.relay_on      = relay_q;
  assign relay.relay_changed = changed_q;

endmodule

`default_nettype wire

// File: src/wwrs_cfg_regs.sv
// Configuration registers: override mode and the packed schedule windows.
// Depends on wwrs_pkg.
`default_nettype none

module wwrs_cfg_regs import wwrs_pkg::*; #(
  parameter int unsigned NUM_WINDOWS = 4,
  parameter int unsigned CfgIdxW     = 3
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  output      logic [ModeW-1:0]    mode_o,
  output      window_t             win_o [NUM_WINDOWS]
);

  logic [ModeW-1:0] mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeW'(MODE_SCHEDULE);
    end else if (cfg_we_i && (cfg_idx_i == CfgIdxW'(CfgIdxMode))) begin
      mode_q <= cfg_wdata_i[ModeW-1:0];
    end
  end

  assign mode_o = mode_q;

  for (genvar k = 0; k < NUM_WINDOWS; k++) begin : g_win
    window_t win_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        win_q <= '0;
      end else if (cfg_we_i && (cfg_idx_i == CfgIdxW'(CfgIdxMode + k + 1))) begin
        win_q <= window_t'(cfg_wdata_i);
      end
    end

    assign win_o[k] = win_q;
  end

endmodule

`default_nettype wire

// File: src/wwrs_window_match.sv
// One schedule window: same-day and overnight match against day and minute.
// Depends on wwrs_pkg.
`default_nettype none

module wwrs_window_match import wwrs_pkg::*; (
  input  wire window_t            win_i,
  input  wire logic [DayW-1:0]    day_i,
  input  wire logic [MinuteW-1:0] minute_i,
  output      logic               active_o
);

  logic [DayW-1:0] prev_day;
  logic [7:0]      mask_ext;
  logic            today;
  logic            yesterday;
  logic            win_ok;
  logic            after_on;
  logic            before_off;

  assign prev_day   = (day_i == FirstDay) ? LastDay : day_i - DayW'(1);
  assign mask_ext   = {1'b0, win_i.day_mask};
  assign today      = mask_ext[day_i];
  assign yesterday  = mask_ext[prev_day];
  assign win_ok     = (win_i.on_minute < MinutesPerDay) &&
                      (win_i.off_minute < MinutesPerDay) &&
                      (win_i.on_minute != win_i.off_minute);
  assign after_on   = (minute_i >= win_i.on_minute);
  assign before_off = (minute_i < win_i.off_minute);

  always_comb begin
    if (!win_ok) begin
      active_o = 1'b0;
    end else if (win_i.on_minute < win_i.off_minute) begin
      active_o = today && after_on && before_off;
    end else begin
      active_o = (today && after_on) || (yesterday && before_off);
    end
  end

endmodule

`default_nettype wire
